[sv/flvtf_pkg.sv]
package flvtf_pkg;

    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCountW    = $clog2(QDepth + 1);
    localparam int MaxResults = 20;
    localparam int PosW       = $clog2(MaxResults);

    localparam logic       KindDescriptor = 1'b0;
    localparam logic       KindPayload    = 1'b1;
    localparam logic [7:0] TagTypeVideo   = 8'h09;
    localparam logic [7:0] TagTypeAudio   = 8'h08;
    localparam logic [7:0] VideoKeyHdr    = 8'h17;
    localparam logic [7:0] VideoInterHdr  = 8'h27;
    localparam logic [7:0] AudioAacHdr    = 8'haf;
    localparam logic [7:0] PacketSeqHdr   = 8'h00;
    localparam logic [7:0] PacketRaw      = 8'h01;
    localparam logic [7:0] StreamIdByte   = 8'h00;

    localparam logic [2:0] VideoCodecLen  = 3'd5;
    localparam logic [2:0] AudioCodecLen  = 3'd2;
    localparam int         TagHdrLen      = 11;
    localparam logic [4:0] VideoHdrBytes  = 5'(TagHdrLen + 5);
    localparam logic [4:0] AudioHdrBytes  = 5'(TagHdrLen + 2);
    localparam int         TrailerLen     = 4;

    typedef struct packed {
        logic        kind;
        logic        is_video;
        logic        key_frame;
        logic        codec_config;
        logic [31:0] present_time;
        logic [31:0] decode_time;
        logic [23:0] payload_length;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       tag_end;
    } out_t;

    // one unit of work for the back end: a full tag header or one payload byte
    typedef struct packed {
        logic        is_hdr;
        logic        is_video;
        logic        key_frame;
        logic        codec_config;
        logic        trailer;
        logic [23:0] data_size;
        logic [31:0] decode_time;
        logic [23:0] time_offset;
        logic [7:0]  data_byte;
        logic [31:0] tag_size;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[sv/flvtf_front.sv]
module flvtf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  flvtf_pkg::in_t        s_data,
    input  flvtf_pkg::q_status_t  q_status,
    output logic                  push,
    output flvtf_pkg::job_t       push_job
);

    logic [23:0] bytes_left_reg, bytes_left_next;
    logic [31:0] tag_size_reg, tag_size_next;
    logic        accept;
    logic        is_desc;
    logic [31:0] diff_pd, diff_dp;
    logic [23:0] time_offset;
    logic [23:0] data_size;
    logic [31:0] new_tag_size;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign is_desc = (s_data.kind == flvtf_pkg::KindDescriptor);

    assign diff_pd     = s_data.present_time - s_data.decode_time;
    assign diff_dp     = s_data.decode_time - s_data.present_time;
    assign time_offset = (s_data.present_time >= s_data.decode_time) ?
                         diff_pd[23:0] : diff_dp[23:0];

    assign data_size = s_data.payload_length + {21'd0, s_data.is_video ?
                       flvtf_pkg::VideoCodecLen : flvtf_pkg::AudioCodecLen};
    assign new_tag_size = {8'd0, s_data.payload_length} + {27'd0, s_data.is_video ?
                          flvtf_pkg::VideoHdrBytes : flvtf_pkg::AudioHdrBytes};

    // drop stray payload bytes that arrive outside a tag
    assign push = accept && (is_desc || (bytes_left_reg != 24'd0));

    always_comb begin
        push_job              = '0;
        push_job.is_hdr       = is_desc;
        push_job.is_video     = s_data.is_video;
        push_job.key_frame    = s_data.key_frame;
        push_job.codec_config = s_data.codec_config;
        push_job.data_size    = data_size;
        push_job.decode_time  = s_data.decode_time;
        push_job.time_offset  = time_offset;
        push_job.data_byte    = s_data.data_byte;
        if (is_desc) begin
            push_job.trailer  = (s_data.payload_length == 24'd0);
            push_job.tag_size = new_tag_size;
        end else begin
            push_job.trailer  = (bytes_left_reg == 24'd1);
            push_job.tag_size = tag_size_reg;
        end
    end

    always_comb begin
        bytes_left_next = bytes_left_reg;
        tag_size_next   = tag_size_reg;
        if (accept) begin
            if (is_desc) begin
                bytes_left_next = s_data.payload_length;
                tag_size_next   = new_tag_size;
            end else if (bytes_left_reg != 24'd0) begin
                bytes_left_next = bytes_left_reg - 24'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            tag_size_reg   <= '0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            tag_size_reg   <= tag_size_next;
        end
    end

endmodule

[sv/flvtf_queue.sv]
module flvtf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  flvtf_pkg::job_t       push_job,
    input  logic                  pop,
    output flvtf_pkg::job_t       head_job,
    output flvtf_pkg::q_status_t  q_status
);

    flvtf_pkg::job_t mem_reg [flvtf_pkg::QDepth];
    logic [flvtf_pkg::QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [flvtf_pkg::QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [flvtf_pkg::QCountW-1:0] count_reg, count_next;
    logic                          do_push, do_pop;

    assign q_status.full  = (count_reg == flvtf_pkg::QCountW'(flvtf_pkg::QDepth));
    assign q_status.empty = (count_reg == '0);
    assign do_push  = push && !q_status.full;
    assign do_pop   = pop && !q_status.empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == flvtf_pkg::QPtrW'(flvtf_pkg::QDepth - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == flvtf_pkg::QPtrW'(flvtf_pkg::QDepth - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/flvtf_back.sv]
module flvtf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  flvtf_pkg::job_t       head_job,
    input  flvtf_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output flvtf_pkg::out_t       m_data
);

    logic [flvtf_pkg::PosW-1:0] pos_reg, pos_next;
    logic                       m_valid_reg, m_valid_next;
    flvtf_pkg::out_t            m_data_reg, m_data_next;
    logic                       load;
    logic [4:0]                 body_len;
    logic [flvtf_pkg::PosW-1:0] last_pos;
    logic                       at_last;
    logic [flvtf_pkg::PosW-1:0] trl_off;
    logic [1:0]                 trl_idx;
    logic [7:0]                 body_byte;
    logic [7:0]                 trl_byte;
    logic [7:0]                 ptype;
    flvtf_pkg::out_t            cur_out;

    assign load = !q_status.empty && (!m_valid_reg || m_ready);

    assign body_len = !head_job.is_hdr ? 5'd1 :
                      (head_job.is_video ? flvtf_pkg::VideoHdrBytes
                                         : flvtf_pkg::AudioHdrBytes);
    assign last_pos = flvtf_pkg::PosW'(body_len) - 1'b1 +
                      (head_job.trailer ? flvtf_pkg::PosW'(flvtf_pkg::TrailerLen)
                                        : '0);
    assign at_last  = (pos_reg == last_pos);
    assign trl_off  = pos_reg - flvtf_pkg::PosW'(body_len);
    assign trl_idx  = trl_off[1:0];
    assign ptype    = head_job.codec_config ? flvtf_pkg::PacketSeqHdr
                                            : flvtf_pkg::PacketRaw;

    always_comb begin
        body_byte = flvtf_pkg::StreamIdByte;
        if (!head_job.is_hdr) begin
            body_byte = head_job.data_byte;
        end else begin
            case (pos_reg)
                5'd0:  body_byte = head_job.is_video ? flvtf_pkg::TagTypeVideo
                                                     : flvtf_pkg::TagTypeAudio;
                5'd1:  body_byte = head_job.data_size[23:16];
                5'd2:  body_byte = head_job.data_size[15:8];
                5'd3:  body_byte = head_job.data_size[7:0];
                5'd4:  body_byte = head_job.decode_time[23:16];
                5'd5:  body_byte = head_job.decode_time[15:8];
                5'd6:  body_byte = head_job.decode_time[7:0];
                5'd7:  body_byte = head_job.decode_time[31:24];
                5'd11: begin
                    if (!head_job.is_video) begin
                        body_byte = flvtf_pkg::AudioAacHdr;
                    end else begin
                        body_byte = head_job.key_frame ? flvtf_pkg::VideoKeyHdr
                                                       : flvtf_pkg::VideoInterHdr;
                    end
                end
                5'd12: body_byte = ptype;
                5'd13: body_byte = head_job.time_offset[23:16];
                5'd14: body_byte = head_job.time_offset[15:8];
                5'd15: body_byte = head_job.time_offset[7:0];
                default: body_byte = flvtf_pkg::StreamIdByte;
            endcase
        end
    end

    always_comb begin
        case (trl_idx)
            2'd0:    trl_byte = head_job.tag_size[31:24];
            2'd1:    trl_byte = head_job.tag_size[23:16];
            2'd2:    trl_byte = head_job.tag_size[15:8];
            default: trl_byte = head_job.tag_size[7:0];
        endcase
    end

    always_comb begin
        if (pos_reg >= flvtf_pkg::PosW'(body_len)) begin
            cur_out.out_byte = trl_byte;
            cur_out.tag_end  = (trl_idx == 2'd3);
        end else begin
            cur_out.out_byte = body_byte;
            cur_out.tag_end  = 1'b0;
        end
    end

    assign pop = load && at_last;

    always_comb begin
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = cur_out;
            pos_next     = at_last ? '0 : pos_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= flvtf_pkg::PosW'(flvtf_pkg::MaxResults - 1))
        else $error("byte position beyond longest tag");

    a_mid_job_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != '0 |-> !q_status.empty)
        else $error("job in progress without queue entry");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cur_out.tag_end) |=> (pos_reg == '0))
        else $error("position not reset after trailer");

    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (load && at_last))
        else $error("queue popped before last byte of job");

endmodule

[sv/flv_tag_framer.sv]
// FLV tag framer.
// Input channel (s_valid/s_ready/s_data) takes two kinds of transactions:
// a frame descriptor (kind 0) that opens a tag, and payload bytes (kind 1).
// Output channel (m_valid/m_ready/m_data) carries the tag byte stream, one
// byte per transaction, with tag_end set on the last trailer byte.
// A descriptor yields 16 bytes for video or 13 for audio (tag header plus
// codec bytes); a payload byte yields itself. The final payload byte, or a
// descriptor with zero length, adds a 4-byte previous-tag-size trailer.
// Payload bytes with no open tag are accepted and dropped.
// An accepted transaction goes into the job queue; its bytes leave through
// the single output byte register, one byte per cycle while m_ready is high
// and a job is queued. The input takes one transaction per cycle while the
// 4-entry job queue has room, so a descriptor's header burst backs up input.
// When m_ready is low the output byte holds and the queue fills, then
// s_ready drops. Reset (aresetn low, synchronous) empties the queue, clears
// the output valid and closes any open tag.
module flv_tag_framer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  flvtf_pkg::in_t      s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output flvtf_pkg::out_t     m_data
);

    flvtf_pkg::q_status_t q_status;
    flvtf_pkg::job_t      push_job;
    flvtf_pkg::job_t      head_job;
    logic                 push;
    logic                 pop;

    flvtf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    flvtf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    flvtf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[tb/sv/flv_tag_framer_tb.sv]
`timescale 1ns / 100ps

module flv_tag_framer_tb;

    localparam int CycleLimit = 2_000_000;
    localparam int TailCycles = 24;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    flvtf_pkg::in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    flvtf_pkg::out_t m_data;

    // expected byte stream and the framer state that produces it
    flvtf_pkg::out_t tag_stream_q[$];
    logic [23:0] open_bytes   = '0;
    logic [31:0] trailer_size = '0;

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   sink_hold      = 0;
    bit   src_gaps_on    = 1'b1;
    flvtf_pkg::out_t seen_want;

    flv_tag_framer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // mostly short, now and then long
    function automatic int short_or_long_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(input logic [7:0] value, input logic last);
        flvtf_pkg::out_t b;
        b.out_byte = value;
        b.tag_end  = last;
        tag_stream_q.push_back(b);
    endtask

    task automatic push_trailer();
        push_byte(trailer_size[31:24], 1'b0);
        push_byte(trailer_size[23:16], 1'b0);
        push_byte(trailer_size[15:8], 1'b0);
        push_byte(trailer_size[7:0], 1'b1);
    endtask

    // expected tag bytes for one accepted transaction
    task automatic frame_tag_bytes(input flvtf_pkg::in_t item);
        logic [31:0] data_len;
        logic [31:0] ts_diff;
        logic [7:0]  pkt_type;
        if (item.kind == flvtf_pkg::KindDescriptor) begin
            data_len = {8'd0, item.payload_length}
                     + (item.is_video ? 32'(flvtf_pkg::VideoCodecLen)
                                      : 32'(flvtf_pkg::AudioCodecLen));
            ts_diff  = (item.present_time >= item.decode_time)
                     ? item.present_time - item.decode_time
                     : item.decode_time - item.present_time;
            pkt_type = item.codec_config ? flvtf_pkg::PacketSeqHdr
                                         : flvtf_pkg::PacketRaw;
            trailer_size = 32'(flvtf_pkg::TagHdrLen) + data_len;
            open_bytes   = item.payload_length;

            push_byte(item.is_video ? flvtf_pkg::TagTypeVideo : flvtf_pkg::TagTypeAudio,
                      1'b0);
            push_byte(data_len[23:16], 1'b0);
            push_byte(data_len[15:8], 1'b0);
            push_byte(data_len[7:0], 1'b0);
            push_byte(item.decode_time[23:16], 1'b0);
            push_byte(item.decode_time[15:8], 1'b0);
            push_byte(item.decode_time[7:0], 1'b0);
            push_byte(item.decode_time[31:24], 1'b0);
            repeat (3) push_byte(flvtf_pkg::StreamIdByte, 1'b0);
            if (item.is_video) begin
                push_byte(item.key_frame ? flvtf_pkg::VideoKeyHdr
                                         : flvtf_pkg::VideoInterHdr, 1'b0);
                push_byte(pkt_type, 1'b0);
                push_byte(ts_diff[23:16], 1'b0);
                push_byte(ts_diff[15:8], 1'b0);
                push_byte(ts_diff[7:0], 1'b0);
            end else begin
                push_byte(flvtf_pkg::AudioAacHdr, 1'b0);
                push_byte(pkt_type, 1'b0);
            end
            if (open_bytes == 0)
                push_trailer();
        end else if (open_bytes != 0) begin
            push_byte(item.data_byte, 1'b0);
            open_bytes = open_bytes - 24'd1;
            if (open_bytes == 0)
                push_trailer();
        end
    endtask

    function automatic flvtf_pkg::in_t make_descriptor(input logic video, input logic key,
                                            input logic cfg, input logic [31:0] pts,
                                            input logic [31:0] dts,
                                            input logic [23:0] len);
        flvtf_pkg::in_t d;
        d.kind           = flvtf_pkg::KindDescriptor;
        d.is_video       = video;
        d.key_frame      = key;
        d.codec_config   = cfg;
        d.present_time   = pts;
        d.decode_time    = dts;
        d.payload_length = len;
        d.data_byte      = 8'($urandom);
        return d;
    endfunction

    // payload transaction; the unused fields carry noise
    function automatic flvtf_pkg::in_t make_payload(input logic [7:0] value);
        flvtf_pkg::in_t p;
        p.kind           = flvtf_pkg::KindPayload;
        p.is_video       = 1'($urandom);
        p.key_frame      = 1'($urandom);
        p.codec_config   = 1'($urandom);
        p.present_time   = $urandom;
        p.decode_time    = $urandom;
        p.payload_length = 24'($urandom_range(0, 16777210));
        p.data_byte      = value;
        return p;
    endfunction

    task automatic send_item(input flvtf_pkg::in_t item);
        int gap;
        gap = src_gaps_on ? short_or_long_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        frame_tag_bytes(item);
    endtask

    // hold the input until the output side has caught up
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tag_stream_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (sink_hold == 0) begin
            if (!m_ready) begin
                m_ready   <= 1'b1;
                sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                        : $urandom_range(1, 12);
            end else begin
                m_ready   <= 1'b0;
                sink_hold <= short_or_long_gap();
            end
        end else begin
            sink_hold <= sink_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tag_stream_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h end %0b",
                                          m_data.out_byte, m_data.tag_end));
            end else begin
                seen_want = tag_stream_q.pop_front();
                if (m_data.out_byte !== seen_want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_data.out_byte, seen_want.out_byte));
                if (m_data.tag_end !== seen_want.tag_end)
                    report_mismatch($sformatf("tag_end %0b, want %0b on byte %02h",
                                              m_data.tag_end, seen_want.tag_end,
                                              seen_want.out_byte));
            end
        end
    end

    task automatic test_empty_tags();
        send_item(make_descriptor(1'b1, 1'b1, 1'b1, 32'd40, 32'd0, 24'd0));
        send_item(make_descriptor(1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 24'd0));
    endtask

    task automatic test_codec_variants();
        send_item(make_descriptor(1'b1, 1'b0, 1'b0, 32'h0001_0000, 32'h0000_ff00,
                                  24'd3));
        send_item(make_payload(8'h00));
        send_item(make_payload(8'h5a));
        send_item(make_payload(8'hff));
        send_item(make_descriptor(1'b0, 1'b1, 1'b0, 32'h1234_5678, 32'h8765_4321,
                                  24'd2));
        send_item(make_payload(8'hff));
        send_item(make_payload(8'h00));
    endtask

    task automatic test_timestamp_extremes();
        send_item(make_descriptor(1'b1, 1'b1, 1'b0, 32'hffff_ffff, 32'h0000_0000,
                                  24'd0));
        send_item(make_descriptor(1'b1, 1'b0, 1'b0, 32'h0000_0000, 32'hffff_ffff,
                                  24'd0));
        send_item(make_descriptor(1'b1, 1'b1, 1'b1, 32'h8000_0001, 32'h8000_0001,
                                  24'd1));
        send_item(make_payload(8'ha5));
    endtask

    task automatic test_stray_bytes();
        send_item(make_payload(8'h3c));
        send_item(make_descriptor(1'b0, 1'b0, 1'b0, 32'd7, 32'd9, 24'd1));
        send_item(make_payload(8'hc3));
        send_item(make_payload(8'h77));
    endtask

    // length too long to finish within the cycle limit, so cut it with a new descriptor
    task automatic test_truncated_tag();
        send_item(make_descriptor(1'b1, 1'b1, 1'b0, 32'd100, 32'd200,
                                  24'd16777210));
        send_item(make_payload(8'h81));
        send_item(make_payload(8'h7e));
        send_item(make_descriptor(1'b0, 1'b0, 1'b1, 32'd300, 32'd300, 24'd1));
        send_item(make_payload(8'h42));
    endtask

    function automatic logic [23:0] pick_payload_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 24'd0;
        if (r < 65) return 24'($urandom_range(1, 8));
        if (r < 95) return 24'($urandom_range(9, 40));
        return 24'($urandom_range(41, 160));
    endfunction

    function automatic flvtf_pkg::in_t random_descriptor(input logic [23:0] len);
        logic [31:0] pts;
        logic [31:0] dts;
        int          r;
        pts = $urandom;
        r   = $urandom_range(0, 2);
        if (r == 0)      dts = $urandom;
        else if (r == 1) dts = pts - 32'($urandom_range(0, 2000));
        else             dts = pts + 32'($urandom_range(0, 2000));
        return make_descriptor(1'($urandom), 1'($urandom), 1'($urandom), pts, dts, len);
    endfunction

    task automatic test_random_stream();
        int          counted;
        int          to_send;
        int          mode;
        logic [23:0] len;
        counted = 0;
        while (counted < 336) begin
            src_gaps_on = ($urandom_range(0, 4) != 0);
            mode = $urandom_range(0, 99);
            if (mode < 6 && open_bytes == 0) begin
                send_item(make_payload(8'($urandom)));
                continue;
            end
            len = pick_payload_length();
            send_item(random_descriptor(len));
            counted++;
            // a few tags are cut short by the next descriptor
            to_send = (mode < 18) ? $urandom_range(0, len) : len;
            for (int i = 0; i < to_send; i++) begin
                send_item(make_payload(8'($urandom)));
                counted++;
            end
            if ($urandom_range(0, 29) == 0)
                pause_until_drained();
        end
        src_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_tags();
        test_codec_variants();
        pause_until_drained();
        test_timestamp_extremes();
        test_stray_bytes();
        pause_until_drained();
        test_truncated_tag();
        test_random_stream();

        s_valid <= 1'b0;
        while (tag_stream_q.size() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/flvtf_pkg.sv
sv/flvtf_front.sv
sv/flvtf_queue.sv
sv/flvtf_back.sv
sv/flv_tag_framer.sv
tb/sv/flv_tag_framer_tb.sv
